/* rtl/byte_stream_tokenizer_top_defines.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef BYTE_STREAM_TOKENIZER_TOP_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BST_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BST_ASSERT(name, prop, msg)
`define BST_ASSERT_IMPL(name, ante, cons, msg)
`define BST_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

/* rtl/bst_pkg.sv */
package bst_pkg;

  localparam int unsigned KIND_W = 4;
  localparam int unsigned INT_W  = 31;
  localparam int unsigned LINE_W = 16;

  localparam logic [KIND_W-1:0] TK_EOF      = 4'd0;
  localparam logic [KIND_W-1:0] TK_SEMI     = 4'd1;
  localparam logic [KIND_W-1:0] TK_PLUS     = 4'd2;
  localparam logic [KIND_W-1:0] TK_DASH     = 4'd3;
  localparam logic [KIND_W-1:0] TK_SLASH    = 4'd4;
  localparam logic [KIND_W-1:0] TK_STAR     = 4'd5;
  localparam logic [KIND_W-1:0] TK_LPAREN   = 4'd6;
  localparam logic [KIND_W-1:0] TK_RPAREN   = 4'd7;
  localparam logic [KIND_W-1:0] TK_LBRACE   = 4'd8;
  localparam logic [KIND_W-1:0] TK_RBRACE   = 4'd9;
  localparam logic [KIND_W-1:0] TK_INT      = 4'd10;
  localparam logic [KIND_W-1:0] TK_LINE     = 4'd11;
  localparam logic [KIND_W-1:0] TK_BLOCK    = 4'd12;
  localparam logic [KIND_W-1:0] TK_ERR_CHAR = 4'd13;
  localparam logic [KIND_W-1:0] TK_ERR_EOF  = 4'd14;

  localparam logic [INT_W-1:0]  INT_TOP  = '1;
  localparam logic [LINE_W-1:0] LINE_TOP = '1;

  typedef enum logic [6:0] {
    MODE_IDLE       = 7'b0000001,
    MODE_SLASH      = 7'b0000010,
    MODE_LINE       = 7'b0000100,
    MODE_BLOCK      = 7'b0001000,
    MODE_BLOCK_STAR = 7'b0010000,
    MODE_INT        = 7'b0100000,
    MODE_HALT       = 7'b1000000
  } scan_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [INT_W-1:0]  int_value;
    logic [LINE_W-1:0] line_number;
    logic              last_in_run;
  } token_t;

  // Up to two tokens produced by one input item, head in tok0.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } lex_res_t;

endpackage

/* rtl/bst_if.sv */
interface bst_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface bst_token_if import bst_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [INT_W-1:0]  int_value;
  logic [LINE_W-1:0] line_number;
  logic              last_in_run;

  modport source (output valid, output token_kind, output int_value, output line_number,
                  output last_in_run, input ready);
  modport sink (input valid, input token_kind, input int_value, input line_number,
                input last_in_run, output ready);
endinterface

/* rtl/bst_lex.sv */
module bst_lex
  import bst_pkg::*;
(
  input  scan_mode_t        mode,
  input  logic [INT_W-1:0]  acc,
  input  logic [LINE_W-1:0] nl,
  input  logic [7:0]        ch,
  input  logic              eoi,
  output scan_mode_t        mode_next,
  output logic [INT_W-1:0]  acc_next,
  output logic [LINE_W-1:0] nl_next,
  output lex_res_t          res
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C ||
           c == 8'h0D;
  endfunction

  function automatic logic [KIND_W:0] single_kind(input logic [7:0] c);
    logic [KIND_W:0] r;
    case (c)
      8'h3B:   r = {1'b1, TK_SEMI};
      8'h2B:   r = {1'b1, TK_PLUS};
      8'h2D:   r = {1'b1, TK_DASH};
      8'h2A:   r = {1'b1, TK_STAR};
      8'h28:   r = {1'b1, TK_LPAREN};
      8'h29:   r = {1'b1, TK_RPAREN};
      8'h7B:   r = {1'b1, TK_LBRACE};
      8'h7D:   r = {1'b1, TK_RBRACE};
      default: r = {1'b0, TK_EOF};
    endcase
    return r;
  endfunction

  logic              is_digit;
  logic [3:0]        digit;
  logic [KIND_W:0]   single;
  logic [34:0]       acc_mul;
  logic [INT_W-1:0]  acc_sat;

  // Outcome of a byte seen from the idle mode.
  logic              idle_emit;
  logic [KIND_W-1:0] idle_kind;
  scan_mode_t        idle_mode;
  logic              idle_load;

  // A pending token ended by this item (pre) and the item's own token (post).
  logic              pre_v;
  logic [KIND_W-1:0] pre_kind;
  logic [INT_W-1:0]  pre_val;
  logic              post_v;
  logic [KIND_W-1:0] post_kind;

  token_t            t_pre;
  token_t            t_post;

  assign is_digit = ch >= CH_ZERO && ch <= CH_NINE;
  assign digit    = 4'(ch - CH_ZERO);
  assign single   = single_kind(ch);
  assign acc_mul  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + 35'(digit);
  assign acc_sat  = (acc_mul > 35'(INT_TOP)) ? INT_TOP : acc_mul[INT_W-1:0];

  always_comb begin
    idle_emit = 1'b0;
    idle_kind = TK_EOF;
    idle_mode = MODE_IDLE;
    idle_load = 1'b0;
    if (is_blank(ch)) begin
      idle_mode = MODE_IDLE;
    end else if (single[KIND_W]) begin
      idle_emit = 1'b1;
      idle_kind = single[KIND_W-1:0];
    end else if (ch == CH_SLASH) begin
      idle_mode = MODE_SLASH;
    end else if (is_digit) begin
      idle_mode = MODE_INT;
      idle_load = 1'b1;
    end else begin
      idle_emit = 1'b1;
      idle_kind = TK_ERR_CHAR;
      idle_mode = MODE_HALT;
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    nl_next   = nl;
    pre_v     = 1'b0;
    pre_kind  = TK_EOF;
    pre_val   = '0;
    post_v    = 1'b0;
    post_kind = TK_EOF;
    if (mode == MODE_HALT) begin
      mode_next = MODE_HALT;
    end else if (eoi) begin
      post_v    = 1'b1;
      post_kind = TK_EOF;
      mode_next = MODE_IDLE;
      acc_next  = '0;
      case (mode)
        MODE_SLASH: begin
          pre_v    = 1'b1;
          pre_kind = TK_SLASH;
        end
        MODE_LINE: begin
          pre_v    = 1'b1;
          pre_kind = TK_LINE;
        end
        MODE_INT: begin
          pre_v    = 1'b1;
          pre_kind = TK_INT;
          pre_val  = acc;
        end
        MODE_BLOCK, MODE_BLOCK_STAR: begin
          post_kind = TK_ERR_EOF;
          mode_next = MODE_HALT;
        end
        default: begin
          pre_v = 1'b0;
        end
      endcase
    end else begin
      if (ch == CH_LF && nl != LINE_TOP) begin
        nl_next = nl + 1'b1;
      end
      case (mode)
        MODE_SLASH: begin
          if (ch == CH_SLASH) begin
            mode_next = MODE_LINE;
          end else if (ch == CH_STAR) begin
            mode_next = MODE_BLOCK;
          end else begin
            pre_v     = 1'b1;
            pre_kind  = TK_SLASH;
            post_v    = idle_emit;
            post_kind = idle_kind;
            mode_next = idle_mode;
            if (idle_load) begin
              acc_next = INT_W'(digit);
            end
          end
        end
        MODE_LINE: begin
          if (ch == CH_LF) begin
            pre_v     = 1'b1;
            pre_kind  = TK_LINE;
            mode_next = MODE_IDLE;
          end
        end
        MODE_BLOCK: begin
          if (ch == CH_STAR) begin
            mode_next = MODE_BLOCK_STAR;
          end
        end
        MODE_BLOCK_STAR: begin
          if (ch == CH_SLASH) begin
            pre_v     = 1'b1;
            pre_kind  = TK_BLOCK;
            mode_next = MODE_IDLE;
          end else if (ch != CH_STAR) begin
            mode_next = MODE_BLOCK;
          end
        end
        MODE_INT: begin
          if (is_digit) begin
            acc_next = acc_sat;
          end else begin
            pre_v     = 1'b1;
            pre_kind  = TK_INT;
            pre_val   = acc;
            acc_next  = '0;
            post_v    = idle_emit;
            post_kind = idle_kind;
            mode_next = idle_mode;
          end
        end
        default: begin
          post_v    = idle_emit;
          post_kind = idle_kind;
          mode_next = idle_mode;
          if (idle_load) begin
            acc_next = INT_W'(digit);
          end
        end
      endcase
    end
  end

  always_comb begin
    t_pre             = '0;
    t_pre.token_kind  = pre_kind;
    t_pre.int_value   = pre_val;
    t_pre.line_number = nl_next;
    t_pre.last_in_run = !post_v;
    t_post             = '0;
    t_post.token_kind  = post_kind;
    t_post.line_number = nl_next;
    t_post.last_in_run = 1'b1;
    res.count = 2'(pre_v) + 2'(post_v);
    res.tok0  = pre_v ? t_pre : t_post;
    res.tok1  = t_post;
  end

endmodule

/* rtl/bst_outbuf.sv */
`include "byte_stream_tokenizer_top_defines.svh"

module bst_outbuf
  import bst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  lex_res_t    res,
  output logic        can_take,
  bst_token_if.source tok
);

  logic [1:0] cnt;
  token_t     tok0;
  token_t     tok1;
  logic       pop;

  assign pop      = tok.valid && tok.ready;
  assign can_take = cnt == 2'd0 || (cnt == 2'd1 && pop);

  assign tok.valid       = cnt != 2'd0;
  assign tok.token_kind  = tok0.token_kind;
  assign tok.int_value   = tok0.int_value;
  assign tok.line_number = tok0.line_number;
  assign tok.last_in_run = tok0.last_in_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok0 <= res.tok0;
      tok1 <= res.tok1;
    end else if (pop) begin
      tok0 <= tok1;
    end
  end

  `BST_ASSERT(a_cnt_range, cnt != 2'd3, "result buffer count out of range")
  `BST_ASSERT_IMPL(a_pair_last, cnt == 2'd2, !tok0.last_in_run && tok1.last_in_run,
                   "token pair carries wrong last_in_run marks")
  `BST_ASSERT_IMPL(a_load_room, load, can_take, "result buffer overwritten")

endmodule

/* rtl/byte_stream_tokenizer_top.sv */
// Streaming tokenizer: one source byte, or an end-of-input mark, per transaction
// on char_in; tokens leave one per transaction on token_out.
// An item may cause zero, one or two tokens; last_in_run marks the final token
// of an item, and every end-of-input item before a halt yields an eof or error token.
// An accepted item passes through the input register and the result buffer
// before its first token is offered on token_out.
// Throughput: one item per cycle while token_out does not stall and items give
// at most one token each; a two-token item holds the buffer until both are taken.
// The input register and the two-entry result buffer are decoupled, so a new
// byte is taken while a finished token still waits on token_out.
// When token_out stalls, the result buffer holds, then the input register
// fills, and char_in.ready drops; nothing is lost or repeated.
// Reset clears the scan mode to idle, the literal accumulator, the line count
// and both pipeline stages. After an unrecognized byte or an end of input
// inside a block comment the block emits one error token and then swallows
// every item until the next reset.
module byte_stream_tokenizer_top
  import bst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bst_char_if.sink    char_in,
  bst_token_if.source token_out
);

  logic              in_valid;
  logic [7:0]        in_char;
  logic              in_end;
  logic              advance;
  logic              can_take;

  scan_mode_t        scan_mode;
  scan_mode_t        scan_mode_next;
  logic [INT_W-1:0]  literal_accumulator;
  logic [INT_W-1:0]  literal_accumulator_next;
  logic [LINE_W-1:0] newline_count;
  logic [LINE_W-1:0] newline_count_next;
  lex_res_t          res;

  assign advance       = in_valid && can_take;
  assign char_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.ready) begin
      in_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      in_char <= char_in.char_byte;
      in_end  <= char_in.end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode           <= MODE_IDLE;
      literal_accumulator <= '0;
      newline_count       <= '0;
    end else if (advance) begin
      scan_mode           <= scan_mode_next;
      literal_accumulator <= literal_accumulator_next;
      newline_count       <= newline_count_next;
    end
  end

  bst_lex u_lex (
    .mode      (scan_mode),
    .acc       (literal_accumulator),
    .nl        (newline_count),
    .ch        (in_char),
    .eoi       (in_end),
    .mode_next (scan_mode_next),
    .acc_next  (literal_accumulator_next),
    .nl_next   (newline_count_next),
    .res       (res)
  );

  bst_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res.count != 2'd0),
    .res      (res),
    .can_take (can_take),
    .tok      (token_out)
  );

  `BST_ASSERT_NEXT(a_halt_sticky, scan_mode == MODE_HALT, scan_mode == MODE_HALT,
                   "left the halted mode without reset")
  `BST_ASSERT_IMPL(a_int_only, token_out.valid && token_out.token_kind != TK_INT,
                   token_out.int_value == '0, "nonzero value on a non-integer token")
  `BST_ASSERT_IMPL(a_eof_last, token_out.valid && token_out.token_kind == TK_EOF,
                   token_out.last_in_run, "eof token not last of its item")

endmodule
